FILE: rtl/mssc_pkg.sv
// ----------------------------------------------------------------------------
// mssc_pkg: shared definitions for the MIPS subset core
// Opcode and function codes, item kinds, stream widths and the structs that
// carry write requests between the core and its memories.
// ----------------------------------------------------------------------------
package mssc_pkg;

  // Default size of the byte data memory.
  localparam int unsigned DMEM_BYTES_DEF = 32'd65536;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 128;

  // Item kinds carried on the input tuser bit.
  localparam logic ITEM_EXEC    = 1'b0;
  localparam logic ITEM_PRELOAD = 1'b1;

  // Primary opcodes.
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;
  localparam logic [5:0] OPC_HALT  = 6'h3F;

  // R-type operation, selected by the low three funct bits.
  localparam logic [2:0] FN_ADDU = 3'h1;
  localparam logic [2:0] FN_SUBU = 3'h3;
  localparam logic [2:0] FN_AND  = 3'h4;
  localparam logic [2:0] FN_OR   = 3'h5;
  localparam logic [2:0] FN_NOR  = 3'h7;

  // Register file write request.
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  // Data memory write request: a big-endian word store or a single byte.
  typedef struct packed {
    logic        store;
    logic        preload;
    logic [31:0] data;
  } dm_wr_t;

endpackage

FILE: rtl/mssc_ram.sv
// ----------------------------------------------------------------------------
// mssc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mssc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns the old data on a same-address write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mssc_rf.sv
// ----------------------------------------------------------------------------
// mssc_rf: register file with two read ports
// Two RAM copies serve the rs and rt reads. Valid bits stand in for the reset
// value, and writes that the RAM read cannot see yet are forwarded.
// ----------------------------------------------------------------------------
module mssc_rf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           rd_a_idx,
  input  logic [4:0]           rd_b_idx,
  input  mssc_pkg::rf_wr_t     wr,
  input  mssc_pkg::rf_wr_t     live,
  output logic [31:0]          rd_a,
  output logic [31:0]          rd_b
);

  logic [31:0]      valid;
  logic             a_ok;
  logic             b_ok;
  logic [4:0]       a_idx_q;
  logic [4:0]       b_idx_q;
  logic [31:0]      ram_a;
  logic [31:0]      ram_b;
  mssc_pkg::rf_wr_t fw;

  mssc_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.data),
    .raddr (rd_a_idx),
    .rdata (ram_a)
  );

  mssc_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.data),
    .raddr (rd_b_idx),
    .rdata (ram_b)
  );

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // Read side bookkeeping, sampled with the RAM read.
  always_ff @(posedge clk) begin
    a_ok    <= valid[rd_a_idx];
    b_ok    <= valid[rd_b_idx];
    a_idx_q <= rd_a_idx;
    b_idx_q <= rd_b_idx;
  end

  // The write taken at the read edge is missing from the RAM data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= '0;
    end else begin
      fw <= wr;
    end
  end

  // Newest value first: the pending write, then the last write, then the RAM.
  always_comb begin
    if (live.en && live.idx == a_idx_q) begin
      rd_a = live.data;
    end else if (fw.en && fw.idx == a_idx_q) begin
      rd_a = fw.data;
    end else begin
      rd_a = a_ok ? ram_a : '0;
    end
  end

  always_comb begin
    if (live.en && live.idx == b_idx_q) begin
      rd_b = live.data;
    end else if (fw.en && fw.idx == b_idx_q) begin
      rd_b = fw.data;
    end else begin
      rd_b = b_ok ? ram_b : '0;
    end
  end

endmodule

FILE: rtl/mssc_dmem.sv
// ----------------------------------------------------------------------------
// mssc_dmem: byte data memory in four interleaved banks
// A word touches one byte in each bank, so a big-endian word is read or
// written in a single access. After reset a sweep zeroes one row of all
// banks a cycle. The write taken at the read edge is forwarded per bank.
// ----------------------------------------------------------------------------
module mssc_dmem #(
  parameter int unsigned BYTES = mssc_pkg::DMEM_BYTES_DEF,
  localparam int unsigned AW = $clog2(BYTES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [AW-1:0]    rd_addr,
  output logic [31:0]      rd_word,
  input  logic [AW-1:0]    wr_addr,
  input  mssc_pkg::dm_wr_t wr,
  output logic             busy
);

  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = BYTES / 4;

  logic [RW-1:0] rd_base;
  logic [RW-1:0] wr_base;
  logic [RW-1:0] rd_row   [4];
  logic [RW-1:0] rd_row_q [4];
  logic [RW-1:0] wr_row   [4];
  logic [RW-1:0] fw_row   [4];
  logic [7:0]    wr_data  [4];
  logic [7:0]    fw_data  [4];
  logic [7:0]    ram_q    [4];
  logic [7:0]    bank_q   [4];
  logic [3:0]    wr_en;
  logic [3:0]    fw_en;
  logic [1:0]    rd_lo_q;
  logic [RW-1:0] clr_row;
  logic          clr_first;

  assign rd_base = rd_addr[AW-1:2];
  assign wr_base = wr_addr[AW-1:2];
  assign busy    = (clr_row != '0) || clr_first;

  // Banks below the start lane hold the bytes that spill into the next row.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_row[k] = (2'(k) < rd_addr[1:0]) ? rd_base + RW'(1) : rd_base;
    end
  end

  // Per-bank write enable, row and byte: clearing sweep, word store, preload.
  always_comb begin
    logic [1:0] lane;
    for (int k = 0; k < 4; k++) begin
      lane = 2'(k) - wr_addr[1:0];
      if (busy) begin
        wr_en[k]   = 1'b1;
        wr_row[k]  = clr_row;
        wr_data[k] = '0;
      end else if (wr.store) begin
        wr_en[k]   = 1'b1;
        wr_row[k]  = (2'(k) < wr_addr[1:0]) ? wr_base + RW'(1) : wr_base;
        wr_data[k] = wr.data[8 * (3 - int'(lane)) +: 8];
      end else begin
        wr_en[k]   = wr.preload && (2'(k) == wr_addr[1:0]);
        wr_row[k]  = wr_base;
        wr_data[k] = wr.data[7:0];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    mssc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (wr_en[g]),
      .waddr (wr_row[g]),
      .wdata (wr_data[g]),
      .raddr (rd_row[g]),
      .rdata (ram_q[g])
    );
  end

  // Clearing sweep over all rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_first <= 1'b1;
      clr_row   <= '0;
    end else if (busy) begin
      clr_first <= 1'b0;
      clr_row   <= clr_row + RW'(1);
    end
  end

  // Last write per bank, and the read rows, for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_en <= '0;
    end else begin
      fw_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fw_row   <= wr_row;
    fw_data  <= wr_data;
    rd_row_q <= rd_row;
    rd_lo_q  <= rd_addr[1:0];
  end

  // Pick each bank's byte, then order the lanes most significant first.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bank_q[k] = (fw_en[k] && fw_row[k] == rd_row_q[k]) ? fw_data[k] : ram_q[k];
    end
    for (int i = 0; i < 4; i++) begin
      rd_word[8 * (3 - i) +: 8] = bank_q[rd_lo_q + 2'(i)];
    end
  end

endmodule

FILE: rtl/mips_subset_single_cycle_core.sv
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core: MIPS32 subset core, one instruction per item
// Executes externally fetched instruction words against its own pc, register
// file and byte data memory, and reports every architectural effect.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser selects the request kind (0 executes the word in
//   tdata, 1 preloads one data memory byte). Output stream m_*: one result
//   per request, carrying the next fetch address and the register and memory
//   writes that the request made.
//   On its way to m_tvalid a request is registered in stage 1 with its register
//   file read, in stage 2 with its data memory read, and then committed into
//   the output register. Throughput is one request per cycle once the clear is
//   done and while m_tready stays high. Dependent instructions, including a
//   load followed by its use, go back to back through forwarding around the
//   register file RAM and the four data memory banks.
//   After reset the data memory is cleared one row of four bytes per cycle,
//   over all DMEM_BYTES/4 rows (16384 at the default size); s_tready stays low then.
//   When m_tready is low the result is held; up to three requests stay in
//   flight and s_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // instr[31:0], byte_addr[47:32], byte_value[55:48]
  input  logic [mssc_pkg::IN_W-1:0]  s_tdata,
  // op[0]
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // pc_next[31:0], halted[32], branch_taken[33], reg_write[34],
  // reg_index[39:35], reg_value[71:40], mem_write[72], mem_addr[88:73],
  // mem_value[120:89], zero fill[127:121]
  output logic [mssc_pkg::OUT_W-1:0] m_tdata
);

  localparam int unsigned AW = $clog2(DMEM_BYTES);

  // Flow control.
  logic out_free;
  logic s1_load;
  logic s2_load;
  logic in_acc;
  logic commit;
  logic dm_busy;

  // Stage 1: register file data arrives.
  logic        s1_valid;
  logic        s1_op;
  logic [31:0] s1_instr;
  logic [15:0] s1_baddr;
  logic [7:0]  s1_bval;
  logic [31:0] s1_a;
  logic [31:0] s1_b;
  logic [31:0] s1_sum;

  // Stage 2: data memory word arrives, the request commits.
  logic        s2_valid;
  logic        s2_op;
  logic [31:0] s2_instr;
  logic [15:0] s2_baddr;
  logic [7:0]  s2_bval;
  logic [31:0] s2_a;
  logic [31:0] s2_b;
  logic [31:0] s2_sum;
  logic [31:0] ld_word;

  // Architectural state outside the memories.
  logic        halt;
  logic [31:0] pc;
  logic [31:0] last_alu;

  // Execute results.
  logic [31:0] x_pc;
  logic        x_halt;
  logic        x_taken;
  logic        x_rw;
  logic [4:0]  x_idx;
  logic [31:0] x_val;
  logic        x_mw;
  logic        x_alu_we;
  logic [31:0] x_alu;

  logic [4:0]        rf_a_idx;
  logic [4:0]        rf_b_idx;
  mssc_pkg::rf_wr_t  rf_wr;
  mssc_pkg::rf_wr_t  rf_live;
  logic [AW-1:0]     dm_rd_addr;
  logic [AW-1:0]     dm_wr_addr;
  mssc_pkg::dm_wr_t  dm_wr;

  logic                       out_valid;
  logic [mssc_pkg::OUT_W-1:0] out_data;

  // Each stage moves when the one after it has room.
  assign out_free = !out_valid || m_tready;
  assign s2_load  = !s2_valid || out_free;
  assign s1_load  = !s1_valid || s2_load;
  assign s_tready = s1_load && !dm_busy;
  assign in_acc   = s_tvalid && s_tready;
  assign commit   = s2_valid && out_free;

  // Register reads are issued for the entering request, or reissued on hold.
  assign rf_a_idx = s1_load ? s_tdata[25:21] : s1_instr[25:21];
  assign rf_b_idx = s1_load ? s_tdata[20:16] : s1_instr[20:16];

  mssc_rf u_rf (
    .clk      (clk),
    .rst      (rst),
    .rd_a_idx (rf_a_idx),
    .rd_b_idx (rf_b_idx),
    .wr       (rf_wr),
    .live     (rf_live),
    .rd_a     (s1_a),
    .rd_b     (s1_b)
  );

  // Effective address: rs plus the sign-extended immediate.
  assign s1_sum = s1_a + {{16{s1_instr[15]}}, s1_instr[15:0]};

  assign dm_rd_addr = s2_load ? s1_sum[AW-1:0] : s2_sum[AW-1:0];
  assign dm_wr_addr = (s2_op == mssc_pkg::ITEM_PRELOAD) ? AW'(s2_baddr) : s2_sum[AW-1:0];

  mssc_dmem #(.BYTES(DMEM_BYTES)) u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (dm_rd_addr),
    .rd_word (ld_word),
    .wr_addr (dm_wr_addr),
    .wr      (dm_wr),
    .busy    (dm_busy)
  );

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op    <= s_tuser;
      s1_instr <= s_tdata[31:0];
      s1_baddr <= s_tdata[47:32];
      s1_bval  <= s_tdata[55:48];
    end
  end

  // Stage 2 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_op    <= s1_op;
      s2_instr <= s1_instr;
      s2_baddr <= s1_baddr;
      s2_bval  <= s1_bval;
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_sum   <= s1_sum;
    end
  end

  // Execute: decode the word in stage 2 against the current pc and flags.
  always_comb begin
    logic [31:0] pc4;
    logic [31:0] simm;
    logic        wen;
    logic [4:0]  dest;
    logic [31:0] wval;
    pc4      = pc + 32'd4;
    simm     = {{16{s2_instr[15]}}, s2_instr[15:0]};
    wen      = 1'b0;
    dest     = s2_instr[15:11];
    wval     = '0;
    x_pc     = pc;
    x_halt   = halt;
    x_taken  = 1'b0;
    x_mw     = 1'b0;
    x_alu_we = 1'b0;
    x_alu    = s2_sum;
    if (s2_op == mssc_pkg::ITEM_EXEC && !halt) begin
      x_pc = pc4;
      case (s2_instr[31:26])
        mssc_pkg::OPC_RTYPE: begin
          case (s2_instr[2:0])
            mssc_pkg::FN_ADDU: x_alu = s2_a + s2_b;
            mssc_pkg::FN_SUBU: x_alu = s2_a - s2_b;
            mssc_pkg::FN_AND:  x_alu = s2_a & s2_b;
            mssc_pkg::FN_OR:   x_alu = s2_a | s2_b;
            mssc_pkg::FN_NOR:  x_alu = ~(s2_a | s2_b);
            default:           x_alu = last_alu;
          endcase
          x_alu_we = 1'b1;
          wen      = 1'b1;
          wval     = x_alu;
        end
        mssc_pkg::OPC_J: begin
          x_pc    = {pc4[31:28], s2_instr[25:0], 2'b00};
          x_taken = 1'b1;
        end
        mssc_pkg::OPC_HALT: begin
          x_halt = 1'b1;
          x_pc   = pc;
        end
        mssc_pkg::OPC_ADDIU: begin
          x_alu_we = 1'b1;
          wen      = 1'b1;
          dest     = s2_instr[20:16];
          wval     = s2_sum;
        end
        mssc_pkg::OPC_LW: begin
          x_alu_we = 1'b1;
          wen      = 1'b1;
          dest     = s2_instr[20:16];
          wval     = ld_word;
        end
        mssc_pkg::OPC_SW: begin
          x_alu_we = 1'b1;
          x_mw     = 1'b1;
        end
        mssc_pkg::OPC_BEQ: begin
          x_alu_we = 1'b1;
          if (s2_a == s2_b) begin
            x_pc    = pc4 + {simm[29:0], 2'b00};
            x_taken = 1'b1;
          end
        end
        default: begin
          x_pc = pc4;
        end
      endcase
    end
    // Register zero stays zero: its writes are dropped and not reported.
    x_rw  = wen && dest != 5'd0;
    x_idx = x_rw ? dest : 5'd0;
    x_val = x_rw ? wval : 32'd0;
  end

  // Write requests: the pending one forwards, the committed one writes.
  assign rf_live.en   = s2_valid && x_rw;
  assign rf_live.idx  = x_idx;
  assign rf_live.data = x_val;
  assign rf_wr.en     = commit && x_rw;
  assign rf_wr.idx    = x_idx;
  assign rf_wr.data   = x_val;

  assign dm_wr.store   = commit && x_mw;
  assign dm_wr.preload = commit && s2_op == mssc_pkg::ITEM_PRELOAD;
  assign dm_wr.data    = (s2_op == mssc_pkg::ITEM_PRELOAD) ? {24'd0, s2_bval} : s2_b;

  // Architectural registers update when the request commits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      halt     <= 1'b0;
      last_alu <= '0;
    end else if (commit) begin
      pc   <= x_pc;
      halt <= x_halt;
      if (x_alu_we) begin
        last_alu <= x_alu;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= {7'd0,
                   x_mw ? s2_b : 32'd0,
                   x_mw ? 16'(s2_sum[AW-1:0]) : 16'd0,
                   x_mw,
                   x_val,
                   x_idx,
                   x_rw,
                   x_taken,
                   x_halt,
                   x_pc};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef ASSERT_OFF
  // No request enters while the data memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    dm_busy |-> !in_acc)
    else $error("request accepted during data memory clear");

  // The pc only moves when a request commits.
  a_pc_on_commit: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(pc))
    else $error("pc changed without a commit");

  // Once halted, the core stays halted and the pc stays put.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt && $stable(pc))
    else $error("halt released or pc moved after halt");

  // Register zero is never written.
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> rf_wr.idx != 5'd0)
    else $error("write to register zero");

  // A commit never both stores a word and preloads a byte.
  a_one_dm_write: assert property (@(posedge clk) disable iff (rst)
    !(dm_wr.store && dm_wr.preload))
    else $error("store and preload in the same commit");
`endif

endmodule
